FILE: rtl/core/esu_pkg.sv
package esu_pkg;

	// character codes used by the decoder
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CTRL_LOW     = 8'h41;
	localparam logic [7:0] CTRL_HIGH    = 8'h5F;
	localparam logic [7:0] CTRL_OFFSET  = 8'h40;

	// one decoded character
	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} esu_char_t;

	// what one input beat produces: zero, one or two characters
	typedef struct packed {
		logic [1:0] count;
		esu_char_t  first;
		esu_char_t  second;
	} esu_result_t;

endpackage

FILE: rtl/core/esu_decode.sv
module esu_decode
	import esu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  char_in,
	input  logic        last_in,
	output esu_result_t result
);

	localparam logic [1:0] MODE_NORMAL    = 2'd0;
	localparam logic [1:0] MODE_BACKSLASH = 2'd1;
	localparam logic [1:0] MODE_DIGITS    = 2'd2;
	localparam logic [1:0] MODE_CARET     = 2'd3;
	localparam logic [1:0] MAX_DIGITS     = 2'd3;

	logic [1:0] mode_q, mode_d;
	logic [7:0] value_q, value_d;
	logic [1:0] count_q, count_d;

	logic       is_digit;
	logic [7:0] digit_val;
	logic [7:0] acc_val;
	logic [1:0] acc_count;
	logic [7:0] lower_c;
	logic [7:0] letter_map;

	always_comb begin
		is_digit  = char_in inside {[8'h30:8'h39]};
		digit_val = char_in - CH_ZERO;
		acc_val   = {value_q[4:0], 3'b000} + digit_val;
		acc_count = count_q + 2'd1;
		lower_c   = (char_in inside {[8'h41:8'h5A]}) ? (char_in + 8'h20) : char_in;
		case (lower_c)
			8'h65:   letter_map = CH_ESC;
			8'h6E:   letter_map = 8'h0A;
			8'h72:   letter_map = 8'h0D;
			8'h74:   letter_map = 8'h09;
			8'h62:   letter_map = 8'h08;
			8'h66:   letter_map = 8'h0C;
			default: letter_map = char_in;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		value_d = value_q;
		count_d = count_q;
		result  = '0;
		case (mode_q)
			MODE_BACKSLASH: begin
				if (is_digit && !last_in) begin
					mode_d  = MODE_DIGITS;
					value_d = digit_val;
					count_d = 2'd1;
				end else begin
					result.count        = 2'd1;
					result.first.data   = is_digit ? digit_val : letter_map;
					result.first.eos    = last_in;
					mode_d  = MODE_NORMAL;
					value_d = '0;
					count_d = '0;
				end
			end
			MODE_DIGITS: begin
				if (is_digit) begin
					if (acc_count == MAX_DIGITS || last_in) begin
						result.count      = 2'd1;
						result.first.data = acc_val;
						result.first.eos  = last_in;
						mode_d  = MODE_NORMAL;
						value_d = '0;
						count_d = '0;
					end else begin
						value_d = acc_val;
						count_d = acc_count;
					end
				end else begin
					// run closed by a non-digit: value first, then the byte as in normal mode
					result.count      = 2'd1;
					result.first.data = value_q;
					result.first.eos  = 1'b0;
					value_d = '0;
					count_d = '0;
					mode_d  = MODE_NORMAL;
					if (last_in) begin
						result.count       = 2'd2;
						result.second.data = char_in;
						result.second.eos  = 1'b1;
					end else if (char_in == CH_BACKSLASH) begin
						mode_d = MODE_BACKSLASH;
					end else if (char_in == CH_CARET) begin
						mode_d = MODE_CARET;
					end else begin
						result.count       = 2'd2;
						result.second.data = char_in;
					end
				end
			end
			MODE_CARET: begin
				result.count      = 2'd1;
				result.first.data = (char_in >= CTRL_LOW && char_in <= CTRL_HIGH) ?
					(char_in - CTRL_OFFSET) : char_in;
				result.first.eos  = last_in;
				mode_d  = MODE_NORMAL;
				value_d = '0;
				count_d = '0;
			end
			default: begin
				if (last_in) begin
					result.count      = 2'd1;
					result.first.data = char_in;
					result.first.eos  = 1'b1;
				end else if (char_in == CH_BACKSLASH) begin
					mode_d = MODE_BACKSLASH;
				end else if (char_in == CH_CARET) begin
					mode_d = MODE_CARET;
				end else begin
					result.count      = 2'd1;
					result.first.data = char_in;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			value_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			value_q <= value_d;
			count_q <= count_d;
		end
	end

	// accumulator is only live inside a digit run
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_DIGITS |-> (value_q == 8'd0 && count_q == 2'd0))
		else $error("digit state not cleared outside a run");

	// a run of three is emitted at once, so the count never rests at three
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != MAX_DIGITS)
		else $error("digit count held at maximum");

	// end of string always flushes the mode
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_in) |=> mode_q == MODE_NORMAL)
		else $error("state not flushed after last beat");

endmodule

FILE: rtl/core/escape_sequence_unescaper_unit.sv
// an accepted beat is held in the input register, then decoded into the
// four-entry output queue
// throughput: one input beat per cycle while the output queue has room for two
// characters; a beat that yields two characters is absorbed by the output queue
// reset: arst_n clears the decode mode, digit accumulator, input stage and queue
module escape_sequence_unescaper_unit
	import esu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast    // end_of_string
);

	localparam int unsigned QDEPTH = 4;

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       advance;

	// output queue of decoded characters
	esu_char_t  queue_q [QDEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] fill_q;
	logic [2:0] fill_d;
	logic       pop;
	logic [1:0] push_count;

	esu_result_t result;

	// the stage retires its beat only when two queue slots are free,
	// so a double result never overflows
	assign advance       = valid_s1 && (fill_q <= 3'd2);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	esu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.char_in (char_s1),
		.last_in (last_s1),
		.result  (result)
	);

	assign push_count = advance ? result.count : 2'd0;
	assign pop        = m_axis_tvalid && m_axis_tready;
	assign fill_d     = fill_q + {1'b0, push_count} - {2'b00, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_count;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			fill_q   <= fill_d;
		end
	end

	// queue entries: first character at the write pointer, second right after
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			queue_q[wr_ptr_q] <= result.first;
		end
		if (push_count == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= result.second;
		end
	end

	assign m_axis_tvalid = (fill_q != 3'd0);
	assign m_axis_tdata  = queue_q[rd_ptr_q].data;
	assign m_axis_tlast  = queue_q[rd_ptr_q].eos;

	// queue never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'(QDEPTH))
		else $error("output queue overflow");

	// pointers and fill count stay consistent
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 3'd0 || fill_q == 3'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");

	// a stalled stage keeps its beat
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(char_s1) && $stable(last_s1)))
		else $error("input stage lost a beat while stalled");

	// a beat never retires into a queue without room for two characters
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> fill_q <= 3'(QDEPTH - 2))
		else $error("stage retired without room");

endmodule

FILE: bench/escape_sequence_unescaper_unit_tb.sv
module escape_sequence_unescaper_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import esu_pkg::*;

	// decoder states of the predictor
	typedef enum logic [1:0] {
		DEC_NORMAL,
		DEC_BACKSLASH,
		DEC_DIGITS,
		DEC_CARET
	} dec_mode_e;

	localparam logic [7:0] CH_NINE     = CH_ZERO + 8'd9;
	localparam int         RUN_DIGITS  = 3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SETTLE      = 8;
	localparam logic [7:0] ESC_LETTERS [6] = '{"e", "n", "r", "t", "b", "f"};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic       s_axis_tlast = 1'b0;    // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic       m_axis_tlast;           // end_of_string

	// expected decoded characters, oldest first
	esu_char_t pending_chars[$];
	esu_char_t want;

	// predictor state
	dec_mode_e  dec_mode = DEC_NORMAL;
	logic [7:0] octal_acc = 8'h00;
	logic [1:0] digit_cnt = 2'd0;

	// idling percentages of the two sides
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;

	// long receiver hold-off, requested by a test and counted by its own process
	int unsigned hold_request = 0;
	int unsigned hold_len;
	logic        sink_hold = 1'b0;

	int unsigned errors = 0;
	int unsigned cycles = 0;

	escape_sequence_unescaper_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic void expect_char(logic [7:0] data, logic eos);
		esu_char_t ch;
		ch.data = data;
		ch.eos  = eos;
		pending_chars.push_back(ch);
	endfunction

	function automatic void clear_decoder();
		dec_mode  = DEC_NORMAL;
		octal_acc = 8'h00;
		digit_cnt = 2'd0;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// backslash + letter, case folded; anything else passes unchanged
	function automatic logic [7:0] letter_code(logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
		case (lc)
			"e": return CH_ESC;
			"n": return 8'h0A;
			"r": return 8'h0D;
			"t": return 8'h09;
			"b": return 8'h08;
			"f": return 8'h0C;
			default: return c;
		endcase
	endfunction

	// a byte seen in normal mode; a lone introducer at end of string passes through
	function automatic void normal_byte(logic [7:0] c, logic last);
		if (last) begin
			expect_char(c, 1'b1);
			clear_decoder();
		end else if (c == CH_BACKSLASH) begin
			dec_mode = DEC_BACKSLASH;
		end else if (c == CH_CARET) begin
			dec_mode = DEC_CARET;
		end else begin
			expect_char(c, 1'b0);
		end
	endfunction

	// works out the characters one accepted input beat yields
	function automatic void decode_expect(logic [7:0] c, logic last);
		case (dec_mode)
			DEC_NORMAL: normal_byte(c, last);
			DEC_BACKSLASH: begin
				if (is_digit(c)) begin
					octal_acc = c - CH_ZERO;
					digit_cnt = 2'd1;
					dec_mode  = DEC_DIGITS;
					if (last) begin
						expect_char(octal_acc, 1'b1);
						clear_decoder();
					end
				end else begin
					expect_char(letter_code(c), last);
					clear_decoder();
				end
			end
			DEC_DIGITS: begin
				if (is_digit(c)) begin
					// base-8 accumulation, 8 and 9 included, kept to 8 bits
					octal_acc = {octal_acc[4:0], 3'b000} + (c - CH_ZERO);
					digit_cnt = digit_cnt + 2'd1;
					if (digit_cnt >= RUN_DIGITS || last) begin
						expect_char(octal_acc, last);
						clear_decoder();
					end
				end else begin
					// run ended by a non-digit: value first, then the byte as usual
					expect_char(octal_acc, 1'b0);
					clear_decoder();
					normal_byte(c, last);
				end
			end
			default: begin
				if (c >= CTRL_LOW && c <= CTRL_HIGH)
					expect_char(c - CTRL_OFFSET, last);
				else
					expect_char(c, last);
				clear_decoder();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// sender, receiver, checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// offers one beat, with random gaps before it, and waits for acceptance
	task automatic send_beat(logic [7:0] b, logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		decode_expect(b, last);
	endtask

	// sends a literal string, tlast on its final byte if asked
	task automatic send_text(string s, logic end_flag);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], end_flag && i == s.len() - 1);
	endtask

	// random strings of plain bytes, letter, digit and caret escapes, and random bytes
	task automatic send_random_strings(int unsigned n_beats);
		logic [7:0] buf_q[$];
		int unsigned sent;
		int unsigned n_tok;
		int unsigned kind;
		logic [7:0] c;
		sent = 0;
		while (sent < n_beats) begin
			buf_q.delete();
			n_tok = $urandom_range(1, 6);
			for (int t = 0; t < n_tok; t++) begin
				kind = $urandom_range(0, 9);
				case (kind)
					0, 1, 2: buf_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
					3: begin
						c = ESC_LETTERS[$urandom_range(0, 5)];
						if ($urandom_range(0, 1))
							c = c - 8'h20;
						buf_q.push_back(CH_BACKSLASH);
						buf_q.push_back(c);
					end
					4, 5: begin
						// one to four digits: a fourth one is an ordinary byte
						buf_q.push_back(CH_BACKSLASH);
						repeat ($urandom_range(1, 4))
							buf_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					end
					6: begin
						buf_q.push_back(CH_CARET);
						if ($urandom_range(0, 9) < 7)
							buf_q.push_back(8'($urandom_range(8'h3E, 8'h62)));
						else
							buf_q.push_back(8'($urandom_range(0, 255)));
					end
					7: buf_q.push_back(8'($urandom_range(0, 255)));
					default: begin
						buf_q.push_back(CH_BACKSLASH);
						buf_q.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end
			// now and then a dangling introducer ends the string
			if ($urandom_range(0, 7) == 0)
				buf_q.push_back($urandom_range(0, 1) ? CH_BACKSLASH : CH_CARET);
			foreach (buf_q[i])
				send_beat(buf_q[i], i == buf_q.size() - 1);
			sent += buf_q.size();
		end
	endtask

	// stops offering, waits until every expected character has come, then lets the pipe settle
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver ready, random unless a hold-off is running
	always @(posedge clk)
		m_axis_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_idle_pct);

	// counts out a requested receiver hold-off
	always begin
		wait (hold_request != 0);
		hold_len     = hold_request;
		hold_request = 0;
		sink_hold   <= 1'b1;
		repeat (hold_len) @(posedge clk);
		sink_hold   <= 1'b0;
	end

	// compares every output beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected beat data %02h last %0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = pending_chars.pop_front();
				if (m_axis_tdata !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						m_axis_tdata, want.data));
				if (m_axis_tlast !== want.eos)
					report_mismatch($sformatf("end_of_string %0b, expected %0b (byte %02h)",
						m_axis_tlast, want.eos, want.data));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding",
				cycles, pending_chars.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// field extremes, every escape kind and several corners of the digit runs
	task automatic test_directed();
		send_text("\\e", 1'b0);
		send_text("^A", 1'b0);
		send_text("^_", 1'b0);
		send_text("^@", 1'b0);      // outside the control range, caret dropped
		send_text("\\7775", 1'b0);  // run of three, then a plain digit
		send_text("\\9^x", 1'b0);   // run ended by a byte that opens a caret escape
		send_text("\\", 1'b1);      // lone backslash at end of string
		send_text("^", 1'b1);       // lone caret at end of string
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_text("\\2", 1'b1);     // digit run cut by the last byte
		send_text("\\q", 1'b1);     // unknown letter, backslash dropped
		wait_drain();
	endtask

	task automatic test_random(int unsigned n_beats);
		send_random_strings(n_beats);
		wait_drain();
	endtask

	// receiver stalls long while the sender keeps offering, so the input backs up
	task automatic test_backpressure();
		int unsigned keep_src;
		keep_src     = src_idle_pct;
		src_idle_pct = 0;
		hold_request = 300;
		send_random_strings(60);
		src_idle_pct = keep_src;
		wait_drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 35;
		sink_idle_pct = 64;
		test_directed();
		test_random(380);

		src_idle_pct  = 64;
		sink_idle_pct = 35;
		test_random(380);
		test_backpressure();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random(380);

		wait_drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
